FILE: design/lpr_pkg.sv
// Shared constants for the LRU page replacement core.
// Holds field widths, register reset value, fault ceiling and opcodes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  // Widths of the fixed fields on the ports.
  localparam int PAGE_PORT_W  = 5;
  localparam int FRAME_PORT_W = 5;
  localparam int CFG_W        = 6;
  localparam int COUNT_W      = 32;

  // Register reset value and fault counter ceiling.
  localparam logic [CFG_W-1:0]   FRAMES_RESET = 6'd4;
  localparam logic [COUNT_W-1:0] FAULT_MAX    = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

FILE: design/lru_page_replacement_core.sv
// LRU page replacement core: page table in one RAM, resident bits in flops.
// Depends on lpr_pkg and lpr_ram.
// A hit goes through decide and hit; a clear or a free-frame miss ends in decide; a miss
// that evicts scans all pages (one RAM read per page to find the oldest entry), then evicts.
// The next transfer can start in the cycle done is high; results never stall.
// Synchronous reset empties the table, zeroes the counters and sets frames_in_use to 4.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement_core #(
  parameter int PAGES      = 32,
  parameter int MAX_FRAMES = 32,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Command channel.
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic                             opcode,
  input  wire logic [lpr_pkg::PAGE_PORT_W-1:0]  page,
  // Result channel, one strobe per command.
  output      logic                             done,
  output      logic                             hit,
  output      logic [lpr_pkg::FRAME_PORT_W-1:0] frame,
  output      logic                             evicted_valid,
  output      logic [lpr_pkg::PAGE_PORT_W-1:0]  evicted_page,
  output      logic [lpr_pkg::COUNT_W-1:0]      fault_count,
  // Configuration write channel for frames_in_use.
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [lpr_pkg::CFG_W-1:0]        cfg_data
);

  import lpr_pkg::*;

  // Widths derived from the parameters.
  localparam int PAGE_W  = $clog2(PAGES);
  localparam int FR_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ENTRY_W = FR_W + TIME_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_HIT,
    S_SCAN,
    S_SCAN_END,
    S_EVICT
  } state_t;

  // Reduce a port page number modulo PAGES by conditional subtraction of
  // PAGES scaled by 16, 8, 4, 2 and 1.
  function automatic logic [PAGE_W-1:0] page_index(input logic [PAGE_PORT_W-1:0] p);
    int v;
    v = int'(p);
    for (int k = 4; k >= 0; k--) begin
      if (v >= (PAGES << k)) begin
        v = v - (PAGES << k);
      end
    end
    return PAGE_W'(v);
  endfunction

  state_t                state;
  logic                  op_q;
  logic [PAGE_W-1:0]     pg_q;
  logic [PAGES-1:0]      resident;
  logic [TIME_BITS-1:0]  access_clock;
  logic [CNT_W-1:0]      frames_handed_out;
  logic [COUNT_W-1:0]    faults;
  logic [CFG_W-1:0]      frames_in_use;

  // Victim scan bookkeeping. scan_idx is the address being read; chk_idx is
  // the address whose data is on the RAM output this cycle.
  logic [PAGE_W-1:0]     scan_idx;
  logic [PAGE_W-1:0]     chk_idx;
  logic                  chk_valid;
  logic                  found;
  logic [TIME_BITS-1:0]  best_age;
  logic [PAGE_W-1:0]     victim;
  logic [FR_W-1:0]       victim_frame;

  // Page table RAM: frame number and last-use time per page.
  logic                  ram_we;
  logic [PAGE_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [FR_W-1:0]       rd_frame;
  logic [TIME_BITS-1:0]  rd_time;

  logic [LIM_W-1:0]      limit;
  logic                  frames_full;
  logic [COUNT_W-1:0]    faults_next;
  logic [TIME_BITS-1:0]  age;
  logic                  better;

  lpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pg_q),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_frame  = ram_rdata[ENTRY_W-1:TIME_BITS];
  assign rd_time   = ram_rdata[TIME_BITS-1:0];
  assign ram_raddr = (state == S_SCAN) ? scan_idx : pg_q;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // A register value of zero acts as one frame; values above MAX_FRAMES are clamped.
  always_comb begin
    if (frames_in_use == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(frames_in_use) > LIM_W'(MAX_FRAMES)) begin
      limit = LIM_W'(MAX_FRAMES);
    end else begin
      limit = LIM_W'(frames_in_use);
    end
  end

  assign frames_full = (LIM_W'(frames_handed_out) >= limit);
  assign faults_next = (faults == FAULT_MAX) ? faults : faults + 1'b1;

  // Age of the entry on the RAM output; wraps modulo 2^TIME_BITS. The first
  // resident entry always wins, later ones only if strictly older.
  assign age    = access_clock - rd_time;
  assign better = chk_valid && resident[chk_idx] && (!found || (age > best_age));

  // Write-back of the accessed page's entry, always stamped with the current time.
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {rd_frame, access_clock};
    unique case (state)
      S_DECIDE: begin
        ram_we    = (op_q == OP_ACCESS) && !resident[pg_q] && !frames_full;
        ram_wdata = {FR_W'(frames_handed_out), access_clock};
      end
      S_HIT: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_frame, access_clock};
      end
      S_EVICT: begin
        ram_we    = 1'b1;
        ram_wdata = {(found ? victim_frame : FR_W'(0)), access_clock};
      end
      S_IDLE, S_SCAN, S_SCAN_END: begin
        ram_we    = 1'b0;
      end
      default: begin
        ram_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      resident          <= '0;
      access_clock      <= '0;
      frames_handed_out <= '0;
      faults            <= '0;
      frames_in_use     <= FRAMES_RESET;
      done              <= 1'b0;
      chk_valid         <= 1'b0;
      found             <= 1'b0;
    end else begin
      done <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        frames_in_use <= cfg_data;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= opcode;
            pg_q  <= page_index(page);
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (op_q == OP_CLEAR) begin
            // Clear empties the table and returns an all-zero result.
            resident          <= '0;
            access_clock      <= '0;
            frames_handed_out <= '0;
            faults            <= '0;
            hit               <= 1'b0;
            frame             <= '0;
            evicted_valid     <= 1'b0;
            evicted_page      <= '0;
            fault_count       <= '0;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else if (resident[pg_q]) begin
            // The RAM read of this page was issued in this cycle.
            state <= S_HIT;
          end else if (!frames_full) begin
            // Miss with a free frame: hand out the next one in order.
            resident[pg_q]    <= 1'b1;
            frames_handed_out <= frames_handed_out + 1'b1;
            faults            <= faults_next;
            access_clock      <= access_clock + 1'b1;
            hit               <= 1'b0;
            frame             <= FRAME_PORT_W'(frames_handed_out);
            evicted_valid     <= 1'b0;
            evicted_page      <= '0;
            fault_count       <= faults_next;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else begin
            // Miss with all frames taken: scan every page for the oldest one.
            faults    <= faults_next;
            scan_idx  <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            state     <= S_SCAN;
          end
        end

        S_HIT: begin
          access_clock  <= access_clock + 1'b1;
          hit           <= 1'b1;
          frame         <= FRAME_PORT_W'(rd_frame);
          evicted_valid <= 1'b0;
          evicted_page  <= '0;
          fault_count   <= faults;
          done          <= 1'b1;
          state         <= S_IDLE;
        end

        S_SCAN: begin
          if (better) begin
            found        <= 1'b1;
            best_age     <= age;
            victim       <= chk_idx;
            victim_frame <= rd_frame;
          end
          chk_valid <= 1'b1;
          chk_idx   <= scan_idx;
          if (scan_idx == PAGE_W'(PAGES - 1)) begin
            state <= S_SCAN_END;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        S_SCAN_END: begin
          // Last entry arrives from the RAM.
          if (better) begin
            found        <= 1'b1;
            best_age     <= age;
            victim       <= chk_idx;
            victim_frame <= rd_frame;
          end
          chk_valid <= 1'b0;
          state     <= S_EVICT;
        end

        S_EVICT: begin
          if (found) begin
            resident[victim] <= 1'b0;
          end
          resident[pg_q] <= 1'b1;
          access_clock   <= access_clock + 1'b1;
          hit            <= 1'b0;
          frame          <= found ? FRAME_PORT_W'(victim_frame) : '0;
          evicted_valid  <= found;
          evicted_page   <= found ? PAGE_PORT_W'(victim) : '0;
          fault_count    <= faults;
          done           <= 1'b1;
          state          <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result strobe is raised only on the way back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // A result follows only a decision, a hit completion or an eviction.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(state) == S_DECIDE || $past(state) == S_HIT ||
                     $past(state) == S_EVICT))
    else $error("result strobe from an unexpected state");

  // An eviction never reports a hit.
  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    (done && evicted_valid) |-> !hit)
    else $error("eviction reported on a hit");

  // Frames are never handed out beyond the physical frame count.
  a_frames_bound: assert property (@(posedge clk) disable iff (rst)
    (LIM_W'(frames_handed_out) <= LIM_W'(MAX_FRAMES)))
    else $error("free frame counter overran");

endmodule

`default_nettype wire

FILE: design/lpr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the page table of the LRU page replacement core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpr_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
